// ===== rtl/core/enacc_pkg.sv =====
// enacc_pkg: types, constants and helpers of the error-norm accumulator.
// No dependencies; used by enacc_out_if and all modules of the block.
package enacc_pkg;

    localparam int ABS_W      = 24;
    localparam int REL_W      = 32;
    localparam int SUM_W      = 64;
    localparam int IDX_W      = 4;
    localparam int FRAC_W     = 16;
    localparam int NCOMP_W    = 5;
    localparam int DIV_STEPS  = 32;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ABS_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REL_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NCOMP   = 2'd2;

    localparam logic [ABS_W-1:0]   ABS_ALL   = '1;
    localparam logic [REL_W-1:0]   REL_ALL   = '1;
    localparam logic [NCOMP_W-1:0] NCOMP_RST = 5'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_ACC
    } state_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic div_step;
        logic mul;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [SUM_W-1:0] abs_sum;
        logic [SUM_W-1:0] abs_sq;
        logic [ABS_W-1:0] abs_peak;
        logic [SUM_W-1:0] rel_sum;
        logic [SUM_W-1:0] rel_sq;
        logic [REL_W-1:0] rel_peak;
    } entry_t;

    typedef struct packed {
        logic [IDX_W-1:0] component_index;
        logic [ABS_W-1:0] abs_error;
        logic [REL_W-1:0] rel_error;
        logic             both_exceed;
        logic [SUM_W-1:0] abs_l1_sum;
        logic [SUM_W-1:0] abs_sq_sum;
        logic [ABS_W-1:0] abs_max;
        logic [SUM_W-1:0] rel_l1_sum;
        logic [SUM_W-1:0] rel_sq_sum;
        logic [REL_W-1:0] rel_max;
        logic             set_fails;
        logic             end_of_set;
    } result_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] x,
                                                 input logic [SUM_W-1:0] y);
        logic [SUM_W:0] s;
        begin
            s = {1'b0, x} + {1'b0, y};
            sat_add = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/enacc_ifs.sv =====
// enacc_ifs: valid/ready request channels of the error-norm accumulator.
// Depends on enacc_pkg for field widths.
interface enacc_in_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] a_value;
    logic signed [SAMPLE_WIDTH-1:0] b_value;
    logic                           last_of_set;

    modport source (output valid, output a_value, output b_value, output last_of_set,
                    input ready);
    modport sink   (input valid, input a_value, input b_value, input last_of_set,
                    output ready);
endinterface

interface enacc_out_if;
    logic                            valid;
    logic                            ready;
    logic [enacc_pkg::IDX_W-1:0]     component_index;
    logic [enacc_pkg::ABS_W-1:0]     abs_error;
    logic [enacc_pkg::REL_W-1:0]     rel_error;
    logic                            both_exceed;
    logic [enacc_pkg::SUM_W-1:0]     abs_l1_sum;
    logic [enacc_pkg::SUM_W-1:0]     abs_sq_sum;
    logic [enacc_pkg::ABS_W-1:0]     abs_max;
    logic [enacc_pkg::SUM_W-1:0]     rel_l1_sum;
    logic [enacc_pkg::SUM_W-1:0]     rel_sq_sum;
    logic [enacc_pkg::REL_W-1:0]     rel_max;
    logic                            set_fails;
    logic                            end_of_set;

    modport source (output valid, output component_index, output abs_error,
                    output rel_error, output both_exceed, output abs_l1_sum,
                    output abs_sq_sum, output abs_max, output rel_l1_sum,
                    output rel_sq_sum, output rel_max, output set_fails,
                    output end_of_set, input ready);
    modport sink   (input valid, input component_index, input abs_error,
                    input rel_error, input both_exceed, input abs_l1_sum,
                    input abs_sq_sum, input abs_max, input rel_l1_sum,
                    input rel_sq_sum, input rel_max, input set_fails,
                    input end_of_set, output ready);
endinterface

// ===== rtl/core/enacc_ctrl.sv =====
// enacc_ctrl: sequencing state machine of the error-norm accumulator.
// Depends on enacc_pkg (state_t, cmd_t, status_t).
module enacc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  enacc_pkg::status_t status,
    output logic               ready,
    output enacc_pkg::cmd_t    cmd
);

    enacc_pkg::state_t state_reg;
    enacc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= enacc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ready      = 1'b0;
        case (state_reg)
            enacc_pkg::S_IDLE:
            begin
                ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = enacc_pkg::S_PREP;
                end
            end
            enacc_pkg::S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = enacc_pkg::S_DIV;
            end
            enacc_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = enacc_pkg::S_MUL;
                end
            end
            enacc_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = enacc_pkg::S_ACC;
            end
            enacc_pkg::S_ACC:
            begin
                // hold until the result register can take the new result
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = enacc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = enacc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/enacc_dp.sv =====
// enacc_dp: datapath of the error-norm accumulator: config registers, error
// calculation, radix-2 divider, per-component store and result register.
// Depends on enacc_pkg and enacc_ifs.
module enacc_dp #(
    parameter int MAX_COMPONENTS = 16,
    parameter int SAMPLE_WIDTH   = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  enacc_pkg::cmd_t                     cmd,
    output enacc_pkg::status_t                  status,
    input  logic                                cfg_wr_en,
    input  logic [enacc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [enacc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic [SAMPLE_WIDTH-1:0]             a_value,
    input  logic [SAMPLE_WIDTH-1:0]             b_value,
    input  logic                                last_of_set,
    enacc_out_if.source                         out
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int NW = $clog2(MAX_COMPONENTS + 1);
    localparam int KW = (NW > enacc_pkg::NCOMP_W) ? NW : enacc_pkg::NCOMP_W;
    localparam int XW = (SW > enacc_pkg::ABS_W) ? SW : enacc_pkg::ABS_W;
    localparam int FW = enacc_pkg::FRAC_W;
    localparam int QW = enacc_pkg::REL_W;
    localparam int STEP_WL = enacc_pkg::STEP_W;

    // configuration
    logic [enacc_pkg::ABS_W-1:0]   abs_thr_reg;
    logic [enacc_pkg::REL_W-1:0]   rel_thr_reg;
    logic [enacc_pkg::NCOMP_W-1:0] ncomp_reg;

    // control state
    logic [CW-1:0]                 counter_reg;
    logic [MAX_COMPONENTS-1:0]     valid_reg;
    logic [enacc_pkg::ABS_W-1:0]   ovr_abs_reg;
    logic [enacc_pkg::REL_W-1:0]   ovr_rel_reg;
    logic                          out_valid_reg;
    logic [STEP_WL-1:0]            step_reg;

    // payload
    logic [SW-1:0]                 a_reg;
    logic [SW-1:0]                 b_reg;
    logic                          last_reg;
    logic [CW-1:0]                 c_reg;
    logic [SW-1:0]                 d_reg;
    logic [SW-1:0]                 rem_reg;
    logic [QW-1:0]                 quo_reg;
    logic [enacc_pkg::ABS_W-1:0]   ae_reg;
    logic                          zero_diff_reg;
    logic                          rel_inf_reg;
    logic [2*enacc_pkg::ABS_W-1:0] ae_sq_reg;
    logic [enacc_pkg::REL_W-1:0]   re_reg;
    logic [2*enacc_pkg::REL_W-1:0] re_sq_reg;
    enacc_pkg::entry_t             rd_entry_reg;
    enacc_pkg::result_t            res_reg;

    enacc_pkg::entry_t             store_mem [MAX_COMPONENTS];

    // combinational
    logic [KW-1:0]                 ncomp_x;
    logic [KW-1:0]                 max_x;
    logic [KW-1:0]                 count_eff;
    logic [CW-1:0]                 cur_c;
    logic [KW-1:0]                 c_plus;
    logic [CW-1:0]                 next_c;
    logic [SW-1:0]                 a_mag;
    logic [SW-1:0]                 b_mag;
    logic [SW:0]                   diff_s;
    logic [SW:0]                   diff_neg;
    logic [SW-1:0]                 diff;
    logic [SW-1:0]                 d_min;
    logic [XW-1:0]                 diff_x;
    logic [enacc_pkg::ABS_W-1:0]   ae;
    logic                          ovf;
    logic [SW+47:0]                num_x;
    logic [SW:0]                   trial;
    logic                          ge;
    logic [SW:0]                   sub;
    logic [enacc_pkg::REL_W-1:0]   re_val;
    enacc_pkg::entry_t             old_e;
    enacc_pkg::entry_t             new_e;
    logic                          rel_inf;
    logic [enacc_pkg::ABS_W-1:0]   ov_abs;
    logic [enacc_pkg::REL_W-1:0]   ov_rel;
    logic [CW+enacc_pkg::IDX_W-1:0] c_ext;

    // component index
    always_comb
    begin
        ncomp_x   = KW'(ncomp_reg);
        max_x     = KW'(MAX_COMPONENTS);
        count_eff = (ncomp_x == '0) ? KW'(1) : ((ncomp_x > max_x) ? max_x : ncomp_x);
        cur_c     = (KW'(counter_reg) >= count_eff) ? '0 : counter_reg;
        c_plus    = KW'(c_reg) + KW'(1);
        next_c    = (c_plus >= count_eff) ? '0 : c_plus[CW-1:0];
        c_ext     = (CW + enacc_pkg::IDX_W)'(c_reg);
    end

    // error terms
    always_comb
    begin
        a_mag    = a_reg[SW-1] ? (~a_reg + 1'b1) : a_reg;
        b_mag    = b_reg[SW-1] ? (~b_reg + 1'b1) : b_reg;
        diff_s   = {a_reg[SW-1], a_reg} - {b_reg[SW-1], b_reg};
        diff_neg = ~diff_s + 1'b1;
        diff     = diff_s[SW] ? diff_neg[SW-1:0] : diff_s[SW-1:0];
        d_min    = (a_mag < b_mag) ? a_mag : b_mag;
        diff_x   = XW'(diff);
        ae       = (diff_x > XW'(enacc_pkg::ABS_ALL)) ? enacc_pkg::ABS_ALL
                                                      : diff_x[enacc_pkg::ABS_W-1:0];
        // quotient would not fit in 32 bits
        ovf      = ((SW + FW)'(diff) >= {d_min, FW'(0)});
        num_x    = (SW + 48)'({diff, FW'(0)});
    end

    // divider step
    always_comb
    begin
        trial = {rem_reg, quo_reg[QW-1]};
        ge    = (trial >= {1'b0, d_reg});
        sub   = trial - {1'b0, d_reg};
    end

    always_comb
    begin
        if (zero_diff_reg)
        begin
            re_val = '0;
        end
        else if (rel_inf_reg)
        begin
            re_val = enacc_pkg::REL_ALL;
        end
        else
        begin
            re_val = quo_reg;
        end
    end

    // accumulation
    always_comb
    begin
        old_e          = valid_reg[c_reg] ? rd_entry_reg : '0;
        rel_inf        = (re_reg == enacc_pkg::REL_ALL);
        new_e.abs_sum  = enacc_pkg::sat_add(old_e.abs_sum, enacc_pkg::SUM_W'(ae_reg));
        new_e.abs_sq   = enacc_pkg::sat_add(old_e.abs_sq, enacc_pkg::SUM_W'(ae_sq_reg));
        new_e.abs_peak = (ae_reg > old_e.abs_peak) ? ae_reg : old_e.abs_peak;
        new_e.rel_sum  = rel_inf ? '1
                       : enacc_pkg::sat_add(old_e.rel_sum, enacc_pkg::SUM_W'(re_reg));
        new_e.rel_sq   = rel_inf ? '1
                       : enacc_pkg::sat_add(old_e.rel_sq, enacc_pkg::SUM_W'(re_sq_reg));
        new_e.rel_peak = (re_reg > old_e.rel_peak) ? re_reg : old_e.rel_peak;
        ov_abs         = (ae_reg > ovr_abs_reg) ? ae_reg : ovr_abs_reg;
        ov_rel         = (re_reg > ovr_rel_reg) ? re_reg : ovr_rel_reg;
    end

    always_comb
    begin
        status.div_last = (step_reg == STEP_WL'(enacc_pkg::DIV_STEPS - 1));
        status.out_free = !out_valid_reg || out.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_thr_reg   <= '0;
            rel_thr_reg   <= '0;
            ncomp_reg     <= enacc_pkg::NCOMP_RST;
            counter_reg   <= '0;
            valid_reg     <= '0;
            ovr_abs_reg   <= '0;
            ovr_rel_reg   <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    enacc_pkg::REG_ABS_THR: abs_thr_reg <= cfg_wr_data[enacc_pkg::ABS_W-1:0];
                    enacc_pkg::REG_REL_THR: rel_thr_reg <= cfg_wr_data[enacc_pkg::REL_W-1:0];
                    enacc_pkg::REG_NCOMP:   ncomp_reg   <= cfg_wr_data[enacc_pkg::NCOMP_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.prep)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    valid_reg   <= '0;
                    ovr_abs_reg <= '0;
                    ovr_rel_reg <= '0;
                    counter_reg <= '0;
                end
                else
                begin
                    valid_reg[c_reg] <= 1'b1;
                    ovr_abs_reg      <= ov_abs;
                    ovr_rel_reg      <= ov_rel;
                    counter_reg      <= next_c;
                end
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            a_reg    <= a_value;
            b_reg    <= b_value;
            last_reg <= last_of_set;
            c_reg    <= cur_c;
        end
        if (cmd.prep)
        begin
            d_reg         <= d_min;
            ae_reg        <= ae;
            zero_diff_reg <= (diff == '0);
            rel_inf_reg   <= (a_reg == '0) || (b_reg == '0) || ovf;
            rem_reg       <= num_x[SW+31:32];
            quo_reg       <= num_x[31:0];
            rd_entry_reg  <= store_mem[c_reg];
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? sub[SW-1:0] : trial[SW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
        if (cmd.mul)
        begin
            re_reg    <= re_val;
            ae_sq_reg <= ae_reg * ae_reg;
            re_sq_reg <= re_val * re_val;
        end
        if (cmd.commit)
        begin
            store_mem[c_reg]        <= new_e;
            res_reg.component_index <= c_ext[enacc_pkg::IDX_W-1:0];
            res_reg.abs_error       <= ae_reg;
            res_reg.rel_error       <= re_reg;
            res_reg.both_exceed     <= (ae_reg > abs_thr_reg) && (re_reg > rel_thr_reg);
            res_reg.abs_l1_sum      <= new_e.abs_sum;
            res_reg.abs_sq_sum      <= new_e.abs_sq;
            res_reg.abs_max         <= new_e.abs_peak;
            res_reg.rel_l1_sum      <= new_e.rel_sum;
            res_reg.rel_sq_sum      <= new_e.rel_sq;
            res_reg.rel_max         <= new_e.rel_peak;
            res_reg.set_fails       <= (ov_abs > abs_thr_reg) && (ov_rel > rel_thr_reg);
            res_reg.end_of_set      <= last_reg;
        end
    end

    assign out.valid           = out_valid_reg;
    assign out.component_index = res_reg.component_index;
    assign out.abs_error       = res_reg.abs_error;
    assign out.rel_error       = res_reg.rel_error;
    assign out.both_exceed     = res_reg.both_exceed;
    assign out.abs_l1_sum      = res_reg.abs_l1_sum;
    assign out.abs_sq_sum      = res_reg.abs_sq_sum;
    assign out.abs_max         = res_reg.abs_max;
    assign out.rel_l1_sum      = res_reg.rel_l1_sum;
    assign out.rel_sq_sum      = res_reg.rel_sq_sum;
    assign out.rel_max         = res_reg.rel_max;
    assign out.set_fails       = res_reg.set_fails;
    assign out.end_of_set      = res_reg.end_of_set;

endmodule

// ===== rtl/core/error_norm_accumulator.sv =====
// error_norm_accumulator: top level, joins controller and datapath.
// Depends on enacc_pkg, enacc_ifs, enacc_ctrl and enacc_dp.
//
//   channel  direction  request fields
//   in       sink       a_value, b_value, last_of_set
//   out      source     component_index .. end_of_set, one request per input
//   cfg      write only cfg_wr_en, cfg_index, cfg_wr_data
//
// Requests are taken one at a time: accept, set-up, 32 steps of the radix-2
// divider for the Q16.16 relative error, multiply, accumulate.
// A finished result waits in the output register; the next request is taken
// meanwhile and only its accumulate step waits for that register to drain.
// Reset clears the per-component store at once through valid bits; no sweep.
module error_norm_accumulator #(
    parameter int MAX_COMPONENTS = 16,
    parameter int SAMPLE_WIDTH   = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    enacc_in_if.sink                         in,
    enacc_out_if.source                      out,
    input  logic                             cfg_wr_en,
    input  logic [enacc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [enacc_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    enacc_pkg::cmd_t    cmd;
    enacc_pkg::status_t status;
    logic               ready;

    assign in.ready = ready;

    enacc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .status   (status),
        .ready    (ready),
        .cmd      (cmd)
    );

    enacc_dp #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .a_value     (in.a_value),
        .b_value     (in.b_value),
        .last_of_set (in.last_of_set),
        .out         (out)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in.valid && in.ready) |=> !in.ready)
        else $error("request taken while previous one in progress");

    a_commit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("result register overwritten before drained");

    a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> ($past(cmd.div_step) && $past(status.div_last)))
        else $error("multiply step without full division");

    a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out.valid) |-> $past(cmd.commit))
        else $error("result raised without commit");
`endif

endmodule
